// ===== rtl/sha256_message_hasher_macros.svh =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher: assertion macros
// Shared concurrent assertion wrappers for the hasher RTL.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_HASHER_MACROS_SVH
`define SHA256_MESSAGE_HASHER_MACROS_SVH

`ifndef ASSERT_OFF
// Checked only while reset is released.
`define SHAMH_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");
// Checked at every edge, reset included.
`define SHAMH_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("%m: assertion failed");
`else
`define SHAMH_ASSERT(lbl, clk, rst_n, prop)
`define SHAMH_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/shamh_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher package
// Shared types, sequencer states and the SHA-256 constant tables.
// ----------------------------------------------------------------------------
package shamh_pkg;

    typedef logic [31:0]       t_word;
    typedef logic [7:0][31:0]  t_vars;    // index 0 is a, index 7 is h
    typedef logic [15:0][31:0] t_block;   // index 0 is the first word

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_COMP,
        ST_FOLD,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_DATA,
        PH_EXTRA,
        PH_FINAL
    } t_phase;

    localparam t_vars INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

// ===== rtl/shamh_round.sv =====
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round and one message schedule step, shared by all rounds.
// ----------------------------------------------------------------------------
module shamh_round (
    input  shamh_pkg::t_vars i_vars,
    input  shamh_pkg::t_word i_k,
    input  shamh_pkg::t_word i_w0,
    input  shamh_pkg::t_word i_w1,
    input  shamh_pkg::t_word i_w9,
    input  shamh_pkg::t_word i_w14,
    output shamh_pkg::t_vars o_vars,
    output shamh_pkg::t_word o_w_next
);

    function automatic shamh_pkg::t_word big_sig0(input shamh_pkg::t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic shamh_pkg::t_word big_sig1(input shamh_pkg::t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic shamh_pkg::t_word small_sig0(input shamh_pkg::t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic shamh_pkg::t_word small_sig1(input shamh_pkg::t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    shamh_pkg::t_word t1;
    shamh_pkg::t_word t2;
    shamh_pkg::t_word maj;
    shamh_pkg::t_word chs;

    always_comb begin
        maj = (i_vars[0] & i_vars[1]) ^ (i_vars[0] & i_vars[2]) ^ (i_vars[1] & i_vars[2]);
        chs = (i_vars[4] & i_vars[5]) ^ (~i_vars[4] & i_vars[6]);
        t1  = i_vars[7] + big_sig1(i_vars[4]) + chs + i_k + i_w0;
        t2  = big_sig0(i_vars[0]) + maj;

        o_vars[7] = i_vars[6];
        o_vars[6] = i_vars[5];
        o_vars[5] = i_vars[4];
        o_vars[4] = i_vars[3] + t1;
        o_vars[3] = i_vars[2];
        o_vars[2] = i_vars[1];
        o_vars[1] = i_vars[0];
        o_vars[0] = t1 + t2;
    end

    assign o_w_next = i_w0 + small_sig0(i_w1) + i_w9 + small_sig1(i_w14);

endmodule

// ===== rtl/sha256_message_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Byte-stream SHA-256 with padding, one round per cycle, eight-beat digest.
// ----------------------------------------------------------------------------
// Input stream: one beat per message byte. tdata is the byte, tuser flags
// that tdata carries a byte, tlast ends the message (a tlast beat without a
// byte closes an empty message or one whose last byte has already been sent).
// Output stream: eight beats per message, digest words H0..H7 in order, the
// word index on tuser and tlast on the eighth word.
// Every 64th byte starts a compression that occupies the shared round unit
// for all its rounds and then folds the result into the chaining state;
// no further byte is taken until the fold is done. After tlast the padding
// step runs and then one or two compressions (two when 56 or more bytes of
// the block are used) before the first digest beat is valid. A tlast on
// the 64th byte of a block compresses that block first, then pads into a
// new block that takes a single further compression of its own.
// The input is not ready while a compression runs or the digest is shown.
// A stalled receiver simply holds the current digest beat; nothing is lost.
// Reset loads the initial hash values and clears the length counter; the
// block word store needs no clearing since every byte is written before use.
// ----------------------------------------------------------------------------
`include "sha256_message_hasher_macros.svh"

module sha256_message_hasher #(
    parameter int LENGTH_COUNTER_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Message input
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] msg_byte
    input  logic [0:0]  i_s_tuser,    // [0] byte_valid
    input  logic        i_s_tlast,    // last_byte
    // Digest output
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,    // [31:0] digest_word
    output logic [2:0]  o_m_tuser,    // [2:0] word_index
    output logic        o_m_tlast     // last_word
);

    localparam int CntW = LENGTH_COUNTER_BITS;

    shamh_pkg::t_state r_state, n_state;
    shamh_pkg::t_phase r_phase, n_phase;
    logic              r_last_pend, n_last_pend;
    logic [CntW-1:0]   r_bit_cnt, n_bit_cnt;
    logic [5:0]        r_round, n_round;
    logic [2:0]        r_out_idx, n_out_idx;
    shamh_pkg::t_vars  r_chain, n_chain;
    shamh_pkg::t_vars  r_vars, n_vars;
    shamh_pkg::t_block r_words, n_words;

    logic              s_acc;
    logic              m_acc;
    logic [5:0]        pos;
    logic [63:0]       len64;
    shamh_pkg::t_vars  round_vars;
    shamh_pkg::t_word  sched_next;
    logic              comp_end;
    logic              msg_end;

    assign s_acc = i_s_tvalid && o_s_tready;
    assign m_acc = o_m_tvalid && i_m_tready;
    assign pos   = r_bit_cnt[8:3];
    assign len64 = 64'(r_bit_cnt);

    assign comp_end = (r_state == shamh_pkg::ST_COMP) && (r_round == 6'd63);
    assign msg_end  = m_acc && o_m_tlast;

    shamh_round u_round (
        .i_vars   (r_vars),
        .i_k      (shamh_pkg::ROUND_K[r_round]),
        .i_w0     (r_words[0]),
        .i_w1     (r_words[1]),
        .i_w9     (r_words[9]),
        .i_w14    (r_words[14]),
        .o_vars   (round_vars),
        .o_w_next (sched_next)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            shamh_pkg::ST_IDLE: begin
                if (s_acc) begin
                    if (i_s_tuser[0] && pos == 6'd63) begin
                        n_state = shamh_pkg::ST_COMP;
                    end else if (i_s_tlast) begin
                        n_state = shamh_pkg::ST_PAD;
                    end
                end
            end
            shamh_pkg::ST_PAD,
            shamh_pkg::ST_LEN: begin
                n_state = shamh_pkg::ST_COMP;
            end
            shamh_pkg::ST_COMP: begin
                if (r_round == 6'd63) begin
                    n_state = shamh_pkg::ST_FOLD;
                end
            end
            shamh_pkg::ST_FOLD: begin
                case (r_phase)
                    shamh_pkg::PH_DATA: begin
                        n_state = r_last_pend ? shamh_pkg::ST_PAD : shamh_pkg::ST_IDLE;
                    end
                    shamh_pkg::PH_EXTRA: n_state = shamh_pkg::ST_LEN;
                    default:             n_state = shamh_pkg::ST_OUT;
                endcase
            end
            shamh_pkg::ST_OUT: begin
                if (m_acc && r_out_idx == 3'd7) begin
                    n_state = shamh_pkg::ST_IDLE;
                end
            end
            default: n_state = shamh_pkg::ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        o_s_tready = (r_state == shamh_pkg::ST_IDLE);
        o_m_tvalid = (r_state == shamh_pkg::ST_OUT);
        o_m_tdata  = r_chain[r_out_idx];
        o_m_tuser  = r_out_idx;
        o_m_tlast  = (r_out_idx == 3'd7);
    end

    // Datapath
    always_comb begin
        n_phase     = r_phase;
        n_last_pend = r_last_pend;
        n_bit_cnt   = r_bit_cnt;
        n_round     = r_round;
        n_out_idx   = r_out_idx;
        n_chain     = r_chain;
        n_vars      = r_vars;
        n_words     = r_words;

        case (r_state)
            shamh_pkg::ST_IDLE: begin
                if (s_acc) begin
                    n_phase     = shamh_pkg::PH_DATA;
                    n_last_pend = i_s_tlast;
                    if (i_s_tuser[0]) begin
                        for (int l = 0; l < 4; l++) begin
                            if (pos[1:0] == 2'(l)) begin
                                n_words[pos[5:2]][8*(3-l) +: 8] = i_s_tdata;
                            end
                        end
                        n_bit_cnt = r_bit_cnt + CntW'(8);
                        if (pos == 6'd63) begin
                            n_vars = r_chain;
                        end
                    end
                end
            end
            shamh_pkg::ST_PAD: begin
                // Keep bytes before the end marker, then the marker, then zeros.
                for (int j = 0; j < 16; j++) begin
                    for (int l = 0; l < 4; l++) begin
                        if (6'(j * 4 + l) == pos) begin
                            n_words[j][8*(3-l) +: 8] = shamh_pkg::PAD_BYTE;
                        end else if (6'(j * 4 + l) > pos) begin
                            n_words[j][8*(3-l) +: 8] = 8'h00;
                        end
                    end
                end
                if (pos >= shamh_pkg::LEN_POS) begin
                    n_phase = shamh_pkg::PH_EXTRA;
                end else begin
                    n_phase     = shamh_pkg::PH_FINAL;
                    n_words[14] = len64[63:32];
                    n_words[15] = len64[31:0];
                end
                n_vars = r_chain;
            end
            shamh_pkg::ST_LEN: begin
                n_words     = '0;
                n_words[14] = len64[63:32];
                n_words[15] = len64[31:0];
                n_phase     = shamh_pkg::PH_FINAL;
                n_vars      = r_chain;
            end
            shamh_pkg::ST_COMP: begin
                // The block store doubles as the sliding schedule window.
                n_vars = round_vars;
                for (int i = 0; i < 15; i++) begin
                    n_words[i] = r_words[i+1];
                end
                n_words[15] = sched_next;
                n_round     = r_round + 6'd1;
            end
            shamh_pkg::ST_FOLD: begin
                for (int i = 0; i < 8; i++) begin
                    n_chain[i] = r_chain[i] + r_vars[i];
                end
                n_out_idx = 3'd0;
            end
            shamh_pkg::ST_OUT: begin
                if (m_acc) begin
                    n_out_idx = r_out_idx + 3'd1;
                    if (r_out_idx == 3'd7) begin
                        n_chain   = shamh_pkg::INIT_HASH;
                        n_bit_cnt = '0;
                    end
                end
            end
            default: begin
                n_round = r_round;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= shamh_pkg::ST_IDLE;
            r_phase     <= shamh_pkg::PH_DATA;
            r_last_pend <= 1'b0;
            r_bit_cnt   <= '0;
            r_round     <= '0;
            r_out_idx   <= '0;
            r_chain     <= shamh_pkg::INIT_HASH;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_last_pend <= n_last_pend;
            r_bit_cnt   <= n_bit_cnt;
            r_round     <= n_round;
            r_out_idx   <= n_out_idx;
            r_chain     <= n_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vars  <= n_vars;
        r_words <= n_words;
    end

    `SHAMH_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> r_state == shamh_pkg::ST_IDLE)
    `SHAMH_ASSERT(a_no_overlap, i_clk, i_rst_n, o_m_tvalid |-> !o_s_tready)
    `SHAMH_ASSERT(a_round_idle, i_clk, i_rst_n, r_state != shamh_pkg::ST_COMP |-> r_round == 6'd0)
    `SHAMH_ASSERT(a_comp_fold, i_clk, i_rst_n, comp_end |=> r_state == shamh_pkg::ST_FOLD)
    `SHAMH_ASSERT(a_msg_restart, i_clk, i_rst_n, msg_end |=> (r_bit_cnt == '0 && o_s_tready))

endmodule
